[design/i2ckr_pkg.sv]
`default_nettype none

package i2ckr_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RST    = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd250;
  localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'h40;

  localparam logic [7:0]  KEY_NONE    = 8'd255;
  localparam logic [7:0]  KEY_CODE_M  = 8'd77;
  localparam logic [7:0]  KEY_CODE_HASH = 8'd35;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout;
    logic [6:0]  device_address;
  } cfg_t;

  typedef struct packed {
    logic       ack_failed;
    logic [7:0] key_code;
    logic [4:0] key_position;
    logic       done_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

`default_nettype wire

[design/i2ckr_fsm.sv]
`default_nettype none

module i2ckr_fsm #(
  parameter int KEY_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            read_request,
  input  wire logic            sda_sample,
  input  wire i2ckr_pkg::cfg_t cfg,
  output i2ckr_pkg::result_t   res
);
  import i2ckr_pkg::*;

  localparam int BCW = $clog2(KEY_BITS + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LOW, PH_TX_SET, PH_TX_HIGH,
    PH_AK_LOW, PH_AK_HIGH, PH_AK_POLL, PH_RX_LOW, PH_RX_HIGH,
    PH_MA_LOW, PH_MA_HIGH, PH_SP_LOW, PH_SP_HIGH
  } phase_t;

  phase_t         phase, phase_next;
  logic [15:0]    tick_count, tick_count_next;
  logic [BCW-1:0] bit_count, bit_count_next;
  logic [7:0]     send_shift, send_shift_next;
  logic [BCW-1:0] first_key, first_key_next;
  logic [7:0]     poll_count, poll_count_next;
  logic           sda_reg, sda_reg_next;
  logic           fail_flag, fail_flag_next;

  logic [16:0]    limit;
  logic           ph_end;
  logic           done;
  logic           scl_of, drv_of;
  logic [BCW-1:0] pos;
  logic [7:0]     code;

  // zero phase length acts as one tick
  assign limit  = (cfg.phase_ticks == '0) ? 17'd1 : {1'b0, cfg.phase_ticks};
  assign ph_end = ({1'b0, tick_count} + 17'd1) >= limit;

  always_comb begin
    unique case (phase)
      PH_IDLE, PH_ST_A, PH_ST_B, PH_TX_HIGH, PH_AK_HIGH, PH_AK_POLL,
      PH_RX_HIGH, PH_MA_HIGH, PH_SP_HIGH: scl_of = 1'b1;
      default:                            scl_of = 1'b0;
    endcase
    unique case (phase)
      PH_IDLE, PH_AK_LOW, PH_AK_HIGH, PH_AK_POLL, PH_RX_LOW, PH_RX_HIGH: drv_of = 1'b0;
      default:                                                          drv_of = 1'b1;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_count_next  = bit_count;
    send_shift_next = send_shift;
    first_key_next  = first_key;
    poll_count_next = poll_count;
    sda_reg_next    = sda_reg;
    fail_flag_next  = fail_flag;
    done            = 1'b0;

    if (phase != PH_IDLE && phase != PH_AK_POLL && !ph_end) begin
      tick_count_next = tick_count + 16'd1;
    end

    unique case (phase)
      PH_IDLE: begin
        if (read_request) begin
          fail_flag_next  = 1'b0;
          first_key_next  = '0;
          bit_count_next  = '0;
          sda_reg_next    = 1'b1;
          phase_next      = PH_ST_A;
          tick_count_next = '0;
        end
      end
      PH_ST_A: begin
        if (ph_end) begin
          sda_reg_next    = 1'b0;
          phase_next      = PH_ST_B;
          tick_count_next = '0;
        end
      end
      PH_ST_B: begin
        if (ph_end) begin
          phase_next      = PH_ST_C;
          tick_count_next = '0;
        end
      end
      PH_ST_C: begin
        if (ph_end) begin
          send_shift_next = {cfg.device_address, 1'b1};
          bit_count_next  = '0;
          phase_next      = PH_TX_LOW;
          tick_count_next = '0;
        end
      end
      PH_TX_LOW: begin
        if (ph_end) begin
          sda_reg_next    = send_shift[7];
          phase_next      = PH_TX_SET;
          tick_count_next = '0;
        end
      end
      PH_TX_SET: begin
        if (ph_end) begin
          phase_next      = PH_TX_HIGH;
          tick_count_next = '0;
        end
      end
      PH_TX_HIGH: begin
        if (ph_end) begin
          send_shift_next = {send_shift[6:0], 1'b0};
          tick_count_next = '0;
          if (bit_count + BCW'(1) >= BCW'(8)) begin
            bit_count_next = '0;
            phase_next     = PH_AK_LOW;
          end else begin
            bit_count_next = bit_count + BCW'(1);
            phase_next     = PH_TX_LOW;
          end
        end
      end
      PH_AK_LOW: begin
        if (ph_end) begin
          phase_next      = PH_AK_HIGH;
          tick_count_next = '0;
        end
      end
      PH_AK_HIGH: begin
        if (ph_end) begin
          poll_count_next = '0;
          phase_next      = PH_AK_POLL;
          tick_count_next = '0;
        end
      end
      PH_AK_POLL: begin
        if (!sda_sample) begin
          bit_count_next  = '0;
          phase_next      = PH_RX_LOW;
          tick_count_next = '0;
        end else if (poll_count > cfg.ack_timeout || poll_count == 8'hff) begin
          fail_flag_next  = 1'b1;
          sda_reg_next    = 1'b0;
          phase_next      = PH_SP_LOW;
          tick_count_next = '0;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      PH_RX_LOW: begin
        if (ph_end) begin
          phase_next      = PH_RX_HIGH;
          tick_count_next = '0;
        end
      end
      PH_RX_HIGH: begin
        // data bit taken on the first tick of scl high
        if (tick_count == '0) begin
          bit_count_next = bit_count + BCW'(1);
          if (first_key == '0 && sda_sample) begin
            first_key_next = bit_count + BCW'(1);
          end
        end
        if (ph_end) begin
          tick_count_next = '0;
          if (bit_count_next == BCW'(8)) begin
            sda_reg_next = (first_key_next != '0);
            phase_next   = PH_MA_LOW;
          end else if (bit_count_next >= BCW'(KEY_BITS)) begin
            sda_reg_next = 1'b1;
            phase_next   = PH_MA_LOW;
          end else begin
            phase_next   = PH_RX_LOW;
          end
        end
      end
      PH_MA_LOW: begin
        if (ph_end) begin
          phase_next      = PH_MA_HIGH;
          tick_count_next = '0;
        end
      end
      PH_MA_HIGH: begin
        if (ph_end) begin
          tick_count_next = '0;
          if (sda_reg) begin
            sda_reg_next = 1'b0;
            phase_next   = PH_SP_LOW;
          end else if (bit_count < BCW'(KEY_BITS)) begin
            phase_next   = PH_RX_LOW;
          end else begin
            sda_reg_next = 1'b1;
            phase_next   = PH_MA_LOW;
          end
        end
      end
      PH_SP_LOW: begin
        if (ph_end) begin
          phase_next      = PH_SP_HIGH;
          tick_count_next = '0;
        end
      end
      PH_SP_HIGH: begin
        if (ph_end) begin
          done            = 1'b1;
          sda_reg_next    = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
    endcase
  end

  // raw position to key code; the chip wires keys in reverse per row
  assign pos = fail_flag ? '0 : first_key;

  always_comb begin
    if (pos < BCW'(13)) begin
      case (4'(pos))
        4'd1:    code = 8'd0;
        4'd2:    code = 8'd3;
        4'd3:    code = 8'd2;
        4'd4:    code = 8'd1;
        4'd5:    code = 8'd6;
        4'd6:    code = 8'd5;
        4'd7:    code = 8'd4;
        4'd8:    code = 8'd9;
        4'd9:    code = 8'd8;
        4'd10:   code = 8'd7;
        4'd11:   code = KEY_CODE_M;
        4'd12:   code = KEY_CODE_HASH;
        default: code = KEY_NONE;
      endcase
    end else begin
      code = KEY_NONE;
    end
  end

  always_comb begin
    res.scl_level    = scl_of;
    res.sda_drive    = drv_of;
    res.sda_level    = drv_of & sda_reg;
    res.done_res     = done;
    res.key_position = done ? 5'(pos) : 5'd0;
    res.key_code     = done ? code : KEY_NONE;
    res.ack_failed   = done & fail_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_count  <= '0;
      send_shift <= '0;
      first_key  <= '0;
      poll_count <= '0;
      sda_reg    <= 1'b1;
      fail_flag  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      send_shift <= send_shift_next;
      first_key  <= first_key_next;
      poll_count <= poll_count_next;
      sda_reg    <= sda_reg_next;
      fail_flag  <= fail_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_done_only_in_stop: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> phase == PH_SP_HIGH)
    else $error("done outside stop phase");

  a_key_quiet: assert property (@(posedge clk) disable iff (rst)
    !res.done_res |-> (res.key_position == 5'd0 && res.key_code == KEY_NONE
                       && !res.ack_failed))
    else $error("key fields set without done");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_IDLE && !read_request) |=> phase == PH_IDLE)
    else $error("left idle without request");

  a_fail_no_key: assert property (@(posedge clk) disable iff (rst)
    res.ack_failed |-> res.key_code == KEY_NONE)
    else $error("key code on failed ack");
`endif

endmodule

`default_nettype wire

[design/i2c_touch_key_reader_unit.sv]
`default_nettype none

// bit-banged i2c master that reads a capacitive key chip. every request on
// the input stream is one bus tick: read_request starts a transaction when
// idle, sda_sample is the sda pin level seen that tick. every tick gives
// exactly one result with the scl/sda pin levels to drive and, on the last
// tick of the stop condition, done_res with the key position, key code and
// ack failure flag. one tick is taken every clock while the result slot is
// free or emptied; an accepted request goes through the input register, then
// the phase controller updating its state and the result register together.
// phase_ticks sets the length of each bus phase in ticks, ack_timeout the ack
// polls allowed to see sda high, device_address the 7-bit chip address.
// the user must see that configuration is written only while the stream is
// idle; the block does not enforce this. no clearing pass after reset.
module i2c_touch_key_reader_unit #(
  parameter int KEY_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,  // read_request, sda_sample
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // scl_level, sda_level, sda_drive, key_position[4:0], key_code[7:0], ack_failed
  output logic [23:0]                            m_tdata,
  output logic                                   m_tlast,  // done_res
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [i2ckr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2ckr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2ckr_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  logic    in_req;
  logic    in_sda;
  logic    advance;
  result_t res;
  result_t res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks    <= PHASE_TICKS_RST;
      cfg.ack_timeout    <= ACK_TIMEOUT_RST;
      cfg.device_address <= DEVICE_ADDRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_TICKS:    cfg.phase_ticks    <= cfg_data;
        REG_ACK_TIMEOUT:    cfg.ack_timeout    <= cfg_data[7:0];
        REG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[6:0];
        default:            ;
      endcase
    end
  end

  // the tick in the input register moves on when the result slot is free
  // or being emptied this cycle
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= s_tdata[0];
      in_sda <= s_tdata[1];
    end
  end

  // phase controller: one bus tick per step
  i2ckr_fsm #(
    .KEY_BITS (KEY_BITS)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .read_request (in_req),
    .sda_sample   (in_sda),
    .cfg          (cfg),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {7'd0, res_q.ack_failed, res_q.key_code, res_q.key_position,
                    res_q.sda_drive, res_q.sda_level, res_q.scl_level};
  assign m_tlast = res_q.done_res;

`ifndef SYNTHESIS
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register not loaded");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("pending tick dropped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !advance)
    else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

[bench/i2c_touch_key_reader_unit_tb.sv]
`timescale 1ns / 1ps

module i2c_touch_key_reader_unit_tb;
  import i2ckr_pkg::*;

  localparam int KEY_BITS    = 16;
  localparam int SEG_ITEMS   = 50;    // random bus ticks per flow control mix
  localparam int DRAIN_TICKS = 8;     // input register plus result register, with margin

  // pins seen on an idle bus: scl high, sda released, no result
  localparam result_t IDLE_PINS = {1'b0, KEY_NONE, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1};
  // last stop tick after the address byte went unanswered
  localparam result_t ACK_FAIL_DONE = {1'b1, KEY_NONE, 5'd0, 1'b1, 1'b1, 1'b0, 1'b1};

  // bus phases of the master, in the order a transaction walks them
  typedef enum logic [3:0] {
    ST_IDLE, ST_START_HI, ST_START_LO, ST_START_CLK,
    ST_ADDR_LOW, ST_ADDR_SET, ST_ADDR_HIGH,
    ST_ACK_LOW, ST_ACK_HIGH, ST_ACK_POLL,
    ST_DATA_LOW, ST_DATA_HIGH, ST_MACK_LOW, ST_MACK_HIGH,
    ST_STOP_LOW, ST_STOP_HIGH
  } bus_phase_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_CFG, ROW_XFER} row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t              kind;
    logic                   req;
    logic                   sda;
    logic [7:0]             reps;
    logic [CFG_INDEX_W-1:0] idx;
    logic [15:0]            val;   // register value, or polls before the slave acks
    logic [15:0]            word;  // key bits the slave returns, first bit in bit 0
    logic                   typed;
    result_t                want;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;  // read_request, sda_sample
  logic                   m_tvalid;
  logic                   m_tready;
  // scl_level, sda_level, sda_drive, key_position[4:0], key_code[7:0], ack_failed
  logic [23:0]            m_tdata;
  logic                   m_tlast;  // done_res
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  i2c_touch_key_reader_unit #(.KEY_BITS(KEY_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // master model: register copies and bus state, advanced once per accepted tick
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_phase_ticks = PHASE_TICKS_RST;
  logic [7:0]  cfg_ack_timeout = ACK_TIMEOUT_RST;
  logic [6:0]  cfg_dev_addr    = DEVICE_ADDRESS_RST;

  bus_phase_t  bus_phase = ST_IDLE;
  int unsigned phase_cnt = 0;
  logic [4:0]  bit_cnt   = '0;
  logic [7:0]  tx_shift  = '0;
  logic [4:0]  key_pos   = '0;
  logic [7:0]  poll_cnt  = '0;
  logic        sda_q     = 1'b1;
  logic        ack_err   = 1'b0;

  function automatic logic scl_for(bus_phase_t p);
    case (p)
      ST_START_CLK, ST_ADDR_LOW, ST_ADDR_SET, ST_ACK_LOW,
      ST_DATA_LOW, ST_MACK_LOW, ST_STOP_LOW: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  // sda is released while idle, during the ack wait and while reading data
  function automatic logic drive_for(bus_phase_t p);
    case (p)
      ST_IDLE, ST_ACK_LOW, ST_ACK_HIGH, ST_ACK_POLL,
      ST_DATA_LOW, ST_DATA_HIGH: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  // key pad wiring: raw bit position to key code
  function automatic logic [7:0] key_code_of(logic [4:0] pos);
    case (pos)
      5'd1:  return 8'd0;
      5'd2:  return 8'd3;
      5'd3:  return 8'd2;
      5'd4:  return 8'd1;
      5'd5:  return 8'd6;
      5'd6:  return 8'd5;
      5'd7:  return 8'd4;
      5'd8:  return 8'd9;
      5'd9:  return 8'd8;
      5'd10: return 8'd7;
      5'd11: return KEY_CODE_M;
      5'd12: return KEY_CODE_HASH;
      default: return KEY_NONE;
    endcase
  endfunction

  function automatic void go_to(bus_phase_t p);
    bus_phase = p;
    phase_cnt = 0;
  endfunction

  // pins and result for one bus tick; moves the master model on by that tick
  function automatic result_t bus_tick(logic req, logic sda);
    result_t     r;
    int unsigned limit;
    logic        last;
    logic        first;
    bus_phase_t  p;
    p     = bus_phase;
    limit = (cfg_phase_ticks == 0) ? 1 : cfg_phase_ticks;
    last  = (phase_cnt + 1 >= limit);
    first = (phase_cnt == 0);
    r              = '0;
    r.key_code     = KEY_NONE;
    r.scl_level    = scl_for(p);
    r.sda_drive    = drive_for(p);
    r.sda_level    = drive_for(p) & sda_q;
    // idle and ack polling never count; a phase stops counting on its last tick
    if (p != ST_IDLE && p != ST_ACK_POLL && !last)
      phase_cnt++;
    case (p)
      ST_IDLE: begin
        // a request while busy falls through the other arms untouched
        if (req) begin
          ack_err = 1'b0;
          key_pos = '0;
          bit_cnt = '0;
          sda_q   = 1'b1;
          go_to(ST_START_HI);
        end
      end
      ST_START_HI: begin
        if (last) begin
          sda_q = 1'b0;
          go_to(ST_START_LO);
        end
      end
      ST_START_LO: if (last) go_to(ST_START_CLK);
      ST_START_CLK: begin
        if (last) begin
          tx_shift = {cfg_dev_addr, 1'b1};
          bit_cnt  = '0;
          go_to(ST_ADDR_LOW);
        end
      end
      ST_ADDR_LOW: begin
        if (last) begin
          sda_q = tx_shift[7];
          go_to(ST_ADDR_SET);
        end
      end
      ST_ADDR_SET: if (last) go_to(ST_ADDR_HIGH);
      ST_ADDR_HIGH: begin
        if (last) begin
          tx_shift = tx_shift << 1;
          bit_cnt++;
          if (bit_cnt >= 8) begin
            bit_cnt = '0;
            go_to(ST_ACK_LOW);
          end else begin
            go_to(ST_ADDR_LOW);
          end
        end
      end
      ST_ACK_LOW: if (last) go_to(ST_ACK_HIGH);
      ST_ACK_HIGH: begin
        if (last) begin
          poll_cnt = '0;
          go_to(ST_ACK_POLL);
        end
      end
      ST_ACK_POLL: begin
        if (!sda) begin
          bit_cnt = '0;
          go_to(ST_DATA_LOW);
        end else if (poll_cnt > cfg_ack_timeout || poll_cnt == 8'hFF) begin
          // no ack in time: straight to stop
          ack_err = 1'b1;
          sda_q   = 1'b0;
          go_to(ST_STOP_LOW);
        end else begin
          poll_cnt++;
        end
      end
      ST_DATA_LOW: if (last) go_to(ST_DATA_HIGH);
      ST_DATA_HIGH: begin
        // data is taken on the first tick of scl high
        if (first) begin
          bit_cnt++;
          if (key_pos == 0 && sda)
            key_pos = bit_cnt;
        end
        if (last) begin
          if (bit_cnt == 8) begin
            // end of the first byte: nack and stop early if a key was seen, else ack
            sda_q = (key_pos != 0);
            go_to(ST_MACK_LOW);
          end else if (bit_cnt >= KEY_BITS) begin
            sda_q = 1'b1;
            go_to(ST_MACK_LOW);
          end else begin
            go_to(ST_DATA_LOW);
          end
        end
      end
      ST_MACK_LOW: if (last) go_to(ST_MACK_HIGH);
      ST_MACK_HIGH: begin
        if (last) begin
          if (sda_q) begin
            sda_q = 1'b0;
            go_to(ST_STOP_LOW);
          end else if (bit_cnt < KEY_BITS) begin
            go_to(ST_DATA_LOW);
          end else begin
            sda_q = 1'b1;
            go_to(ST_MACK_LOW);
          end
        end
      end
      ST_STOP_LOW: if (last) go_to(ST_STOP_HIGH);
      default: begin
        if (last) begin
          r.done_res     = 1'b1;
          r.key_position = ack_err ? 5'd0 : key_pos;
          r.key_code     = ack_err ? KEY_NONE : key_code_of(key_pos);
          r.ack_failed   = ack_err;
          sda_q          = 1'b1;
          go_to(ST_IDLE);
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // key chip on the other end of the bus
  // ---------------------------------------------------------------------------
  int          ack_delay  = 0;     // polls seen high before the chip acks
  logic [15:0] key_word   = '0;    // bits the chip returns, first bit read in bit 0
  bit          noise_mode = 1'b0;  // sda random on every tick

  function automatic logic chip_sda();
    if (noise_mode)
      return 1'($urandom_range(1));
    if (bus_phase == ST_ACK_POLL)
      return (poll_cnt >= ack_delay) ? 1'b0 : 1'b1;
    if (bus_phase == ST_DATA_HIGH && phase_cnt == 0)
      return key_word[bit_cnt[3:0]];
    return 1'($urandom_range(1));
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------
  result_t     pin_results_q[$];  // pins and results still owed by the block
  int          gap_pct     = 6;   // chance per cycle that the sender idles
  int          stall_pct   = 72;  // chance per cycle that results are held back
  int          items_sent  = 0;
  bit          typed_on    = 1'b0;
  result_t     typed_val   = '0;

  int          mismatches  = 0;
  int          done_cnt    = 0;
  int          key_cnt     = 0;
  int          fail_cnt    = 0;

  // one bus tick request; called and left on a falling edge
  task automatic send_tick(input logic req, input logic sda, input bit typed,
                           input result_t want);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_on  = typed;
    typed_val = want;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, sda, req};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // register write once every owed result is out
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pin_results_q.size() != 0);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PHASE_TICKS:    cfg_phase_ticks = val;
      REG_ACK_TIMEOUT:    cfg_ack_timeout = val[7:0];
      REG_DEVICE_ADDRESS: cfg_dev_addr    = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one whole key read: request on an idle bus, then ticks until the bus is idle again
  task automatic run_xfer(input int delay, input logic [15:0] word, input bit noisy);
    ack_delay  = delay;
    key_word   = word;
    noise_mode = noisy;
    while (bus_phase != ST_IDLE)
      send_tick(1'($urandom_range(1)), chip_sda(), 1'b0, '0);
    send_tick(1'b1, chip_sda(), 1'b0, '0);
    // requests during a transaction are ignored; sprinkle a few in
    while (bus_phase != ST_IDLE)
      send_tick(noisy ? 1'($urandom_range(1)) : ($urandom_range(7) == 0), chip_sda(),
                1'b0, '0);
  endtask

  function automatic dir_row_t tick_row(logic req, logic sda, int reps);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.req  = req;
    r.sda  = sda;
    r.reps = 8'(reps);
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic req, logic sda, result_t want);
    dir_row_t r;
    r       = tick_row(req, sda, 1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic dir_row_t xfer_row(logic [15:0] delay, logic [15:0] word);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_XFER;
    r.val  = delay;
    r.word = word;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, receiver and scoreboard
  // ---------------------------------------------------------------------------
  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
  end

  always #5 clk = ~clk;

  // result side holds off at random
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= stall_pct);

  // accepted ticks feed the model, accepted results are checked in order
  always @(posedge clk) begin
    result_t r;
    result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        r = bus_tick(s_tdata[0], s_tdata[1]);
        // rows of the directed table that carry their own expectation use it
        pin_results_q.push_back(typed_on ? typed_val : r);
      end
      if (m_tvalid && m_tready) begin
        got.scl_level    = m_tdata[0];
        got.sda_level    = m_tdata[1];
        got.sda_drive    = m_tdata[2];
        got.key_position = m_tdata[7:3];
        got.key_code     = m_tdata[15:8];
        got.ack_failed   = m_tdata[16];
        got.done_res     = m_tlast;
        if (pin_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: result with nothing owed, actual %h last %b",
                     $time, m_tdata, m_tlast);
        end else begin
          r = pin_results_q.pop_front();
          check_field("scl_level", r.scl_level, got.scl_level);
          check_field("sda_level", r.sda_level, got.sda_level);
          check_field("sda_drive", r.sda_drive, got.sda_drive);
          check_field("done_res", r.done_res, got.done_res);
          check_field("key_position", r.key_position, got.key_position);
          check_field("key_code", r.key_code, got.key_code);
          check_field("ack_failed", r.ack_failed, got.ack_failed);
          if (r.done_res) begin
            done_cnt++;
            if (r.ack_failed)
              fail_cnt++;
            else if (r.key_position != 0)
              key_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    rows [24];
    int unsigned stop_at;
    int          n_xfer;
    int          pick;
    int          delay;
    logic [15:0] word;
    bit          noisy;

    // directed part
    rows[0]  = typed_row(1'b0, 1'b0, IDLE_PINS);         // right after reset
    rows[1]  = tick_row(1'b0, 1'b1, 2);                  // idle bus, sda high
    rows[2]  = cfg_row(REG_PHASE_TICKS, 16'hFFFF);       // longest phase
    rows[3]  = typed_row(1'b1, 1'b0, IDLE_PINS);         // request tick still shows idle
    rows[4]  = tick_row(1'b1, 1'b1, 5);                  // requests while busy are ignored
    rows[5]  = cfg_row(REG_PHASE_TICKS, 16'd0);          // zero acts as one, mid-phase
    rows[6]  = cfg_row(REG_ACK_TIMEOUT, 16'd0);
    // start leftover, address byte, ack wait, one retry, then the stop low tick
    rows[7]  = tick_row(1'b0, 1'b1, 32);
    rows[8]  = typed_row(1'b0, 1'b1, ACK_FAIL_DONE);     // no ack: failure result
    rows[9]  = typed_row(1'b0, 1'b0, IDLE_PINS);
    rows[10] = cfg_row(REG_ACK_TIMEOUT, 16'd255);
    rows[11] = cfg_row(REG_DEVICE_ADDRESS, 16'd127);
    rows[12] = xfer_row(16'd0, 16'h0000);                // no key, both bytes read
    rows[13] = xfer_row(16'd1, 16'h0001);                // key in the first byte, early nack
    rows[14] = cfg_row(REG_PHASE_TICKS, 16'd2);
    rows[15] = xfer_row(16'd0, 16'h0800);                // hash key
    rows[16] = xfer_row(16'd2, 16'h0400);                // menu key
    rows[17] = cfg_row(REG_DEVICE_ADDRESS, 16'd0);
    rows[18] = xfer_row(16'd0, 16'h0100);                // key in the second byte
    rows[19] = xfer_row(16'd0, 16'h8000);                // last bit, maps to none
    rows[20] = cfg_row(REG_PHASE_TICKS, 16'd1);
    rows[21] = xfer_row(16'd255, 16'h0080);              // ack on the very last poll
    rows[22] = xfer_row(16'd300, 16'h0000);              // never acked, poll count runs out
    rows[23] = xfer_row(16'd0, 16'hFFFF);                // all bits high, first one wins

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_TICK: repeat (rows[i].reps)
          send_tick(rows[i].req, rows[i].sda, rows[i].typed, rows[i].want);
        ROW_CFG:  write_reg(rows[i].idx, rows[i].val);
        default:  run_xfer(rows[i].val, rows[i].word, 1'b0);
      endcase
    end

    // random part: mostly clean reads with random content, some noise on sda
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin gap_pct = 6;  stall_pct = 72; end
        1: begin gap_pct = 72; stall_pct = 6;  end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      stop_at = items_sent + SEG_ITEMS;
      n_xfer  = 0;
      while (items_sent < stop_at) begin
        if (n_xfer % 3 == 0) begin
          // short phases keep transactions quick
          pick = $urandom_range(19);
          write_reg(REG_PHASE_TICKS,
                    16'((pick == 0) ? 0 : (pick < 15) ? 1 : (pick < 19) ? 2 : 3));
          pick = $urandom_range(9);
          write_reg(REG_ACK_TIMEOUT,
                    16'((pick < 6) ? $urandom_range(4) :
                        (pick < 9) ? $urandom_range(255) : 255));
          write_reg(REG_DEVICE_ADDRESS, 16'($urandom_range(127)));
        end
        repeat ($urandom_range(3))
          send_tick(1'b0, 1'($urandom_range(1)), 1'b0, '0);
        noisy = ($urandom_range(99) < 15);
        pick  = $urandom_range(9);
        delay = (pick < 7) ? $urandom_range(2) :
                (pick < 9) ? $urandom_range(cfg_ack_timeout + 2) : 300;
        pick  = $urandom_range(9);
        if (pick < 3)
          word = 16'h0000;
        else if (pick < 7)
          word = 16'h0001 << $urandom_range(15);
        else
          word = 16'($urandom);
        run_xfer(delay, word, noisy);
        n_xfer++;
      end
    end

    // wait for everything owed, then a few more cycles for stray results
    s_tvalid <= 1'b0;
    while (pin_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_TICKS) @(negedge clk);

    $display("%0d bus ticks, %0d reads finished: %0d found a key, %0d lost the address ack",
             items_sent, done_cnt, key_cnt, fail_cnt);
    $display("phase lengths 0 to 65535, ack limits 0 to 255, addresses 0 to 127, three flow mixes");
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
design/i2ckr_pkg.sv
design/i2ckr_fsm.sv
design/i2c_touch_key_reader_unit.sv
bench/i2c_touch_key_reader_unit_tb.sv
